// File: rtl/core/led_blink_pattern_controller_top_macros.svh
// assertion macros for the led blink controller rtl, used by lbpc_ctrl
// expects clk and rst_n in the scope of every use
`ifndef LED_BLINK_PATTERN_CONTROLLER_TOP_MACROS_SVH
`define LED_BLINK_PATTERN_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define LBPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LBPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lbpc_pkg.sv
// constants, pattern codes and control types of the led blink controller
// no dependencies
`timescale 1ns / 1ps

package lbpc_pkg;

    localparam int NUM_LEDS  = 8;
    localparam int LED_IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

    localparam int MODE_W  = 1;
    localparam int INDEX_W = 3;
    localparam int PAT_W   = 3;
    localparam int CNT_W   = 16;
    localparam int OUT_W   = 8;
    localparam int DIV_W   = 2;

    localparam logic [MODE_W-1:0] MODE_TICK = 1'b0;
    localparam logic [MODE_W-1:0] MODE_CFG  = 1'b1;

    localparam logic [PAT_W-1:0] PAT_OFF     = 3'd0;
    localparam logic [PAT_W-1:0] PAT_ON      = 3'd1;
    localparam logic [PAT_W-1:0] PAT_BLINK   = 3'd2;
    localparam logic [PAT_W-1:0] PAT_FLICKER = 3'd3;
    localparam logic [PAT_W-1:0] PAT_TIMEOUT = 3'd4;

    localparam logic [CNT_W-1:0] CNT_TOP = 16'hFFFF;

    // flicker divider counts 0..2
    localparam logic [DIV_W-1:0] DIV_LAST = 2'd2;

    typedef struct packed {
        logic                 cfg_we;
        logic                 tick_we;
        logic [LED_IDX_W-1:0] idx;
        logic                 load_out;
    } lbpc_cmd_t;

endpackage

// File: rtl/core/lbpc_if.sv
// valid/ready channel interfaces for the led blink controller
// depends on lbpc_pkg
`timescale 1ns / 1ps

interface lbpc_req_if;
    logic                          valid;
    logic                          ready;
    logic [lbpc_pkg::MODE_W-1:0]   mode;
    logic [lbpc_pkg::INDEX_W-1:0]  led_index;
    logic [lbpc_pkg::PAT_W-1:0]    pattern;
    logic [lbpc_pkg::CNT_W-1:0]    on_ticks;
    logic [lbpc_pkg::CNT_W-1:0]    off_ticks;
    logic [lbpc_pkg::CNT_W-1:0]    timeout_ticks;

    modport source (
        output valid, mode, led_index, pattern, on_ticks, off_ticks, timeout_ticks,
        input  ready
    );
    modport sink (
        input  valid, mode, led_index, pattern, on_ticks, off_ticks, timeout_ticks,
        output ready
    );
endinterface

interface lbpc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [lbpc_pkg::OUT_W-1:0]  led_levels;

    modport source (
        output valid, led_levels,
        input  ready
    );
    modport sink (
        input  valid, led_levels,
        output ready
    );
endinterface

// File: rtl/core/lbpc_ctrl.sv
// sequencer of the led blink controller: handshakes, led sweep, output valid
// depends on lbpc_pkg and the assertion macro header
`timescale 1ns / 1ps

`include "led_blink_pattern_controller_top_macros.svh"

module lbpc_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [lbpc_pkg::MODE_W-1:0]       in_mode,
    output logic                              in_ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lbpc_pkg::lbpc_cmd_t               cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_TICK   = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [lbpc_pkg::LED_IDX_W-1:0] idx_reg, idx_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           accept;
    logic                           out_free;
    logic                           last_led;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign last_led  = (idx_reg == lbpc_pkg::LED_IDX_W'(lbpc_pkg::NUM_LEDS - 1));
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.idx        = idx_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode == lbpc_pkg::MODE_CFG)
                    begin
                        cmd.cfg_we = 1'b1;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_TICK;
                    end
                end
            end
            ST_TICK:
            begin
                // one led per cycle
                cmd.tick_we = 1'b1;
                idx_next    = idx_reg + 1'b1;
                if (last_led)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `LBPC_ASSERT_NOW(a_load_needs_free_out, cmd.load_out, out_free,
        "output overwritten before taken")
    `LBPC_ASSERT_NOW(a_sweep_in_bank, state_reg == ST_TICK,
        last_led || (idx_reg < lbpc_pkg::LED_IDX_W'(lbpc_pkg::NUM_LEDS - 1)),
        "sweep index out of bank")
    `LBPC_ASSERT_NEXT(a_tick_starts_sweep, accept && (in_mode == lbpc_pkg::MODE_TICK),
        (state_reg == ST_TICK) && (idx_reg == '0), "tick item did not start sweep")
    `LBPC_ASSERT_NEXT(a_cfg_to_result, accept && (in_mode == lbpc_pkg::MODE_CFG),
        state_reg == ST_RESULT, "configure item did not go to result")

endmodule

// File: rtl/core/lbpc_datapath.sv
// per-led pattern state, one-led tick update and the result register
// depends on lbpc_pkg
`timescale 1ns / 1ps

module lbpc_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lbpc_pkg::lbpc_cmd_t               cmd,
    input  logic [lbpc_pkg::INDEX_W-1:0]      led_index,
    input  logic [lbpc_pkg::PAT_W-1:0]        pattern,
    input  logic [lbpc_pkg::CNT_W-1:0]        on_ticks,
    input  logic [lbpc_pkg::CNT_W-1:0]        off_ticks,
    input  logic [lbpc_pkg::CNT_W-1:0]        timeout_ticks,
    output logic [lbpc_pkg::OUT_W-1:0]        led_levels
);

    localparam int N = lbpc_pkg::NUM_LEDS;

    logic [lbpc_pkg::PAT_W-1:0] pattern_reg [N];
    logic [lbpc_pkg::CNT_W-1:0] on_lim_reg  [N];
    logic [lbpc_pkg::CNT_W-1:0] off_lim_reg [N];
    logic [lbpc_pkg::CNT_W-1:0] tmo_lim_reg [N];
    logic [lbpc_pkg::CNT_W-1:0] cnt_reg     [N];
    logic [lbpc_pkg::DIV_W-1:0] div_reg     [N];
    logic [N-1:0]               phase_reg;
    logic [N-1:0]               flick_reg;
    logic [N-1:0]               pin_reg;
    logic [lbpc_pkg::OUT_W-1:0] levels_reg;

    logic [lbpc_pkg::PAT_W-1:0] cur_pat;
    logic [lbpc_pkg::CNT_W-1:0] cur_cnt;
    logic [lbpc_pkg::CNT_W-1:0] cnt_inc;
    logic [lbpc_pkg::PAT_W-1:0] pat_next;
    logic [lbpc_pkg::CNT_W-1:0] cnt_next;
    logic [lbpc_pkg::DIV_W-1:0] div_next;
    logic                       phase_next;
    logic                       flick_next;
    logic                       pin_next;
    logic                       cfg_in_bank;
    logic [lbpc_pkg::LED_IDX_W-1:0] cfg_idx;
    logic                       cfg_lit;

    assign cur_pat = pattern_reg[cmd.idx];
    assign cur_cnt = cnt_reg[cmd.idx];
    // saturating increment
    assign cnt_inc = (cur_cnt == lbpc_pkg::CNT_TOP) ? cur_cnt : cur_cnt + 1'b1;

    assign cfg_in_bank = (32'(led_index) < N);
    assign cfg_idx     = lbpc_pkg::LED_IDX_W'(led_index);
    assign cfg_lit     = (pattern >= lbpc_pkg::PAT_ON) && (pattern <= lbpc_pkg::PAT_TIMEOUT);

    // tick update of the selected led
    always_comb
    begin
        pat_next   = cur_pat;
        cnt_next   = cur_cnt;
        div_next   = div_reg[cmd.idx];
        phase_next = phase_reg[cmd.idx];
        flick_next = flick_reg[cmd.idx];
        pin_next   = pin_reg[cmd.idx];

        case (cur_pat)
            lbpc_pkg::PAT_BLINK, lbpc_pkg::PAT_FLICKER:
            begin
                if (phase_reg[cmd.idx])
                begin
                    if (cur_cnt > on_lim_reg[cmd.idx])
                    begin
                        cnt_next   = '0;
                        pin_next   = 1'b0;
                        phase_next = 1'b0;
                        if (cur_pat == lbpc_pkg::PAT_FLICKER)
                        begin
                            div_next = '0;
                        end
                    end
                    else
                    begin
                        if (cur_pat == lbpc_pkg::PAT_FLICKER)
                        begin
                            if (div_reg[cmd.idx] == '0)
                            begin
                                flick_next = !flick_reg[cmd.idx];
                                pin_next   = !flick_reg[cmd.idx];
                            end
                            div_next = (div_reg[cmd.idx] == lbpc_pkg::DIV_LAST) ?
                                       '0 : div_reg[cmd.idx] + 1'b1;
                        end
                        cnt_next = cnt_inc;
                    end
                end
                else
                begin
                    if (cur_cnt > off_lim_reg[cmd.idx])
                    begin
                        cnt_next   = '0;
                        pin_next   = 1'b1;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            lbpc_pkg::PAT_TIMEOUT:
            begin
                if (cnt_inc >= tmo_lim_reg[cmd.idx])
                begin
                    cnt_next = '0;
                    pin_next = 1'b0;
                    pat_next = lbpc_pkg::PAT_OFF;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            default:
            begin
                // steady and undefined codes hold
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                pattern_reg[k] <= lbpc_pkg::PAT_OFF;
                on_lim_reg[k]  <= '0;
                off_lim_reg[k] <= '0;
                tmo_lim_reg[k] <= '0;
                cnt_reg[k]     <= '0;
                div_reg[k]     <= '0;
            end
            phase_reg <= '0;
            flick_reg <= '0;
            pin_reg   <= '0;
        end
        else if (cmd.cfg_we && cfg_in_bank)
        begin
            pattern_reg[cfg_idx] <= pattern;
            on_lim_reg[cfg_idx]  <= on_ticks;
            off_lim_reg[cfg_idx] <= off_ticks;
            tmo_lim_reg[cfg_idx] <= timeout_ticks;
            cnt_reg[cfg_idx]     <= '0;
            div_reg[cfg_idx]     <= '0;
            phase_reg[cfg_idx]   <= 1'b1;
            flick_reg[cfg_idx]   <= 1'b1;
            pin_reg[cfg_idx]     <= cfg_lit;
        end
        else if (cmd.tick_we)
        begin
            pattern_reg[cmd.idx] <= pat_next;
            cnt_reg[cmd.idx]     <= cnt_next;
            div_reg[cmd.idx]     <= div_next;
            phase_reg[cmd.idx]   <= phase_next;
            flick_reg[cmd.idx]   <= flick_next;
            pin_reg[cmd.idx]     <= pin_next;
        end
    end

    // result register, only leds 0..7 are visible
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            levels_reg <= lbpc_pkg::OUT_W'(pin_reg);
        end
    end

    assign led_levels = levels_reg;

endmodule

// File: rtl/core/led_blink_pattern_controller_top.sv
// LED blink controller with a bank of lbpc_pkg::NUM_LEDS LEDs. Each item on req is either a
// configure item (mode 1), which loads one LED's pattern, on/off limits and timeout and
// restarts it in its on phase, lit for codes 1..4, or a tick item (mode 0), which advances
// every LED by one tick. Every item returns exactly one result on rsp: the pin levels of LEDs
// 0..7 after the item (1 = lit). Patterns: 0 off, 1 on, 2 blink, 3 flicker blink (pin toggles
// every third on-phase tick), 4 on until timeout; codes 5..7 are stored but stay dark and
// frozen. A configure item to an LED outside the bank is dropped but still answered. One item
// is worked at a time. A configure item is written in its accept cycle; a tick item sweeps the
// bank through the single tick update unit that visits one LED entry per cycle. The result
// sits in an output register, so the next item is accepted while the previous result waits
// on rsp. Reset clears all LED state (all dark).
// depends on lbpc_pkg, lbpc_if, lbpc_ctrl, lbpc_datapath
`timescale 1ns / 1ps

module led_blink_pattern_controller_top (
    input  logic         clk,
    input  logic         rst_n,
    lbpc_req_if.sink     req,
    lbpc_rsp_if.source   rsp
);

    // control bundle from the sequencer to the datapath
    lbpc_pkg::lbpc_cmd_t cmd;

    // sequencer: accepts items, sweeps the bank on a tick, owns rsp.valid
    lbpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_mode   (req.mode),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // datapath: per-led state, one led updated per cycle, result register
    // configure fields are used in the accept cycle only
    lbpc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .led_index     (req.led_index),
        .pattern       (req.pattern),
        .on_ticks      (req.on_ticks),
        .off_ticks     (req.off_ticks),
        .timeout_ticks (req.timeout_ticks),
        .led_levels    (rsp.led_levels)
    );

endmodule

// File: verif/tb_top.sv
// self-checking testbench for led_blink_pattern_controller_top
// depends on lbpc_pkg, lbpc_if and the controller rtl
`timescale 1ns / 1ps

module tb_top;

    // pattern codes that the block stores but never lights
    localparam logic [lbpc_pkg::PAT_W-1:0] PAT_RSVD_FIRST = 3'd5;
    localparam logic [lbpc_pkg::PAT_W-1:0] PAT_RSVD_LAST  = 3'd7;

    // idle odds per side, out of a hundred
    localparam int IDLE_PCT = 38;

    // items in the middle of the run that go through with no idling on either side
    localparam int CALM_FIRST = 300;
    localparam int CALM_LAST  = 420;

    localparam int ITEM_TARGET = 750;

    // one request item as it travels on req
    typedef struct packed {
        logic [lbpc_pkg::MODE_W-1:0]  mode;
        logic [lbpc_pkg::INDEX_W-1:0] led_index;
        logic [lbpc_pkg::PAT_W-1:0]   pattern;
        logic [lbpc_pkg::CNT_W-1:0]   on_ticks;
        logic [lbpc_pkg::CNT_W-1:0]   off_ticks;
        logic [lbpc_pkg::CNT_W-1:0]   timeout_ticks;
    } led_req_t;

    logic clk;
    logic rst_n;

    lbpc_req_if req_if ();
    lbpc_rsp_if rsp_if ();

    led_blink_pattern_controller_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // items waiting to be offered, and the pin levels that must come back, oldest first
    led_req_t                   pend_q[$];
    logic [lbpc_pkg::OUT_W-1:0] levels_q[$];

    led_req_t cur_item;
    int       total_items;
    int       sent_cnt;
    int       seen_cnt;
    int       fails;

    // ------------------------------------------------------------------
    // shadow copy of the led bank, advanced once per accepted item
    // ------------------------------------------------------------------
    logic [lbpc_pkg::PAT_W-1:0] led_pat   [lbpc_pkg::NUM_LEDS];
    logic [lbpc_pkg::CNT_W-1:0] on_lim    [lbpc_pkg::NUM_LEDS];
    logic [lbpc_pkg::CNT_W-1:0] off_lim   [lbpc_pkg::NUM_LEDS];
    logic [lbpc_pkg::CNT_W-1:0] tmo_lim   [lbpc_pkg::NUM_LEDS];
    logic [lbpc_pkg::CNT_W-1:0] tick_cnt  [lbpc_pkg::NUM_LEDS];
    logic                       lit_phase [lbpc_pkg::NUM_LEDS];
    logic                       flk_lvl   [lbpc_pkg::NUM_LEDS];
    logic [lbpc_pkg::DIV_W-1:0] flk_div   [lbpc_pkg::NUM_LEDS];
    logic                       pin_lvl   [lbpc_pkg::NUM_LEDS];

    initial
    begin
        for (int k = 0; k < lbpc_pkg::NUM_LEDS; k++)
        begin
            led_pat[k]   = lbpc_pkg::PAT_OFF;
            on_lim[k]    = '0;
            off_lim[k]   = '0;
            tmo_lim[k]   = '0;
            tick_cnt[k]  = '0;
            lit_phase[k] = 1'b0;
            flk_lvl[k]   = 1'b0;
            flk_div[k]   = '0;
            pin_lvl[k]   = 1'b0;
        end
    end

    // tick counts stick at the top instead of wrapping
    function automatic logic [lbpc_pkg::CNT_W-1:0] sat_inc(logic [lbpc_pkg::CNT_W-1:0] v);
        return (v == lbpc_pkg::CNT_TOP) ? v : v + 1'b1;
    endfunction

    // applies one item to the shadow bank and returns the pin levels after it
    function automatic logic [lbpc_pkg::OUT_W-1:0] bank_step(led_req_t r);
        logic [lbpc_pkg::OUT_W-1:0] levels;
        logic                       flicker;
        levels = '0;
        if (r.mode == lbpc_pkg::MODE_CFG)
        begin
            // configure: load one led and restart it in its on phase, lit for patterns 1..4
            if (r.led_index < lbpc_pkg::NUM_LEDS)
            begin
                led_pat[r.led_index]   = r.pattern;
                on_lim[r.led_index]    = r.on_ticks;
                off_lim[r.led_index]   = r.off_ticks;
                tmo_lim[r.led_index]   = r.timeout_ticks;
                tick_cnt[r.led_index]  = '0;
                lit_phase[r.led_index] = 1'b1;
                flk_lvl[r.led_index]   = 1'b1;
                flk_div[r.led_index]   = '0;
                pin_lvl[r.led_index]   = (r.pattern >= lbpc_pkg::PAT_ON) &&
                                         (r.pattern <= lbpc_pkg::PAT_TIMEOUT);
            end
        end
        else
        begin
            // tick: every led advances once
            for (int k = 0; k < lbpc_pkg::NUM_LEDS; k++)
            begin
                case (led_pat[k])
                    lbpc_pkg::PAT_BLINK, lbpc_pkg::PAT_FLICKER:
                    begin
                        flicker = (led_pat[k] == lbpc_pkg::PAT_FLICKER);
                        if (lit_phase[k])
                        begin
                            if (tick_cnt[k] > on_lim[k])
                            begin
                                // on phase over
                                tick_cnt[k]  = '0;
                                pin_lvl[k]   = 1'b0;
                                lit_phase[k] = 1'b0;
                                if (flicker)
                                    flk_div[k] = '0;
                            end
                            else
                            begin
                                // flicker level toggles on every third on-phase tick
                                if (flicker)
                                begin
                                    if (flk_div[k] == '0)
                                    begin
                                        flk_lvl[k] = ~flk_lvl[k];
                                        pin_lvl[k] = flk_lvl[k];
                                    end
                                    flk_div[k] = (flk_div[k] == lbpc_pkg::DIV_LAST) ?
                                                 '0 : flk_div[k] + 1'b1;
                                end
                                tick_cnt[k] = sat_inc(tick_cnt[k]);
                            end
                        end
                        else if (tick_cnt[k] > off_lim[k])
                        begin
                            // off phase over, back to lit
                            tick_cnt[k]  = '0;
                            pin_lvl[k]   = 1'b1;
                            lit_phase[k] = 1'b1;
                        end
                        else
                        begin
                            tick_cnt[k] = sat_inc(tick_cnt[k]);
                        end
                    end
                    lbpc_pkg::PAT_TIMEOUT:
                    begin
                        // count first, then compare; on expiry the led falls back to off
                        tick_cnt[k] = sat_inc(tick_cnt[k]);
                        if (tick_cnt[k] >= tmo_lim[k])
                        begin
                            tick_cnt[k] = '0;
                            pin_lvl[k]  = 1'b0;
                            led_pat[k]  = lbpc_pkg::PAT_OFF;
                        end
                    end
                    default:
                    begin
                        // steady and reserved codes hold still
                    end
                endcase
            end
        end
        for (int k = 0; k < lbpc_pkg::NUM_LEDS && k < lbpc_pkg::OUT_W; k++)
            levels[k] = pin_lvl[k];
        return levels;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // tick items carry random junk in the fields the block ignores
    task automatic add_tick();
        led_req_t r;
        r.mode          = lbpc_pkg::MODE_TICK;
        r.led_index     = lbpc_pkg::INDEX_W'($urandom);
        r.pattern       = lbpc_pkg::PAT_W'($urandom);
        r.on_ticks      = lbpc_pkg::CNT_W'($urandom);
        r.off_ticks     = lbpc_pkg::CNT_W'($urandom);
        r.timeout_ticks = lbpc_pkg::CNT_W'($urandom);
        pend_q.push_back(r);
        total_items++;
    endtask

    task automatic add_cfg(logic [lbpc_pkg::INDEX_W-1:0] idx, logic [lbpc_pkg::PAT_W-1:0] pat,
                           logic [lbpc_pkg::CNT_W-1:0] on_t, logic [lbpc_pkg::CNT_W-1:0] off_t,
                           logic [lbpc_pkg::CNT_W-1:0] tmo_t);
        led_req_t r;
        r.mode          = lbpc_pkg::MODE_CFG;
        r.led_index     = idx;
        r.pattern       = pat;
        r.on_ticks      = on_t;
        r.off_ticks     = off_t;
        r.timeout_ticks = tmo_t;
        pend_q.push_back(r);
        total_items++;
    endtask

    // mostly short limits so phases turn over often, now and then wide or extreme ones
    function automatic logic [lbpc_pkg::CNT_W-1:0] pick_limit();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return lbpc_pkg::CNT_W'($urandom_range(0, 10));
        else if (roll < 85)
            return lbpc_pkg::CNT_W'($urandom_range(0, 300));
        else if (roll < 95)
            return lbpc_pkg::CNT_W'($urandom);
        else
            return $urandom_range(0, 1) ? lbpc_pkg::CNT_TOP : '0;
    endfunction

    function automatic logic [lbpc_pkg::PAT_W-1:0] pick_pattern();
        if ($urandom_range(0, 9) == 0)
            return lbpc_pkg::PAT_W'($urandom_range(PAT_RSVD_FIRST, PAT_RSVD_LAST));
        return lbpc_pkg::PAT_W'($urandom_range(lbpc_pkg::PAT_OFF, lbpc_pkg::PAT_TIMEOUT));
    endfunction

    // ------------------------------------------------------------------
    // clock, reset and known input levels from time zero
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.mode          = lbpc_pkg::MODE_TICK;
        req_if.led_index     = '0;
        req_if.pattern       = lbpc_pkg::PAT_OFF;
        req_if.on_ticks      = '0;
        req_if.off_ticks     = '0;
        req_if.timeout_ticks = '0;
        rsp_if.ready         = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // driver: offers queued items on req, predicts each one it sees accepted
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                levels_q.push_back(bank_step(cur_item));
                sent_cnt++;
            end
            // a new item may go out once the previous one is gone
            if (!req_if.valid || req_if.ready)
            begin
                if (pend_q.size() > 0 &&
                    ((sent_cnt >= CALM_FIRST && sent_cnt < CALM_LAST) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    cur_item              = pend_q.pop_front();
                    req_if.mode          <= cur_item.mode;
                    req_if.led_index     <= cur_item.led_index;
                    req_if.pattern       <= cur_item.pattern;
                    req_if.on_ticks      <= cur_item.on_ticks;
                    req_if.off_ticks     <= cur_item.off_ticks;
                    req_if.timeout_ticks <= cur_item.timeout_ticks;
                    req_if.valid         <= 1'b1;
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: stalls rsp at random and checks every result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [lbpc_pkg::OUT_W-1:0] want;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                seen_cnt++;
                if (levels_q.size() == 0)
                begin
                    $display("%0t: led_levels expected none, got %b", $time, rsp_if.led_levels);
                    fails++;
                end
                else
                begin
                    want = levels_q.pop_front();
                    if (rsp_if.led_levels !== want)
                    begin
                        $display("%0t: led_levels expected %b, got %b",
                                 $time, want, rsp_if.led_levels);
                        fails++;
                    end
                end
            end
            rsp_if.ready <= (seen_cnt >= CALM_FIRST && seen_cnt < CALM_LAST) ||
                            ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int n_cfg;
        int n_tick;
        total_items = 0;
        sent_cnt    = 0;
        seen_cnt    = 0;
        fails       = 0;

        // directed: all dark, then every pattern on its own led with edge limits
        add_tick();
        add_cfg(7, PAT_RSVD_LAST, lbpc_pkg::CNT_TOP, lbpc_pkg::CNT_TOP,
                lbpc_pkg::CNT_TOP);                                    // all field bits high
        add_cfg(0, lbpc_pkg::PAT_ON, '0, '0, '0);                      // index and limit bits all low
        add_cfg(1, lbpc_pkg::PAT_BLINK, 0, 1, 0);
        add_cfg(2, lbpc_pkg::PAT_FLICKER, 6, 0, 0);
        add_cfg(3, lbpc_pkg::PAT_TIMEOUT, 0, 0, 0);                    // expires on the first tick
        add_cfg(4, lbpc_pkg::PAT_TIMEOUT, 0, 0, 3);
        // top limit never ends the phase
        add_cfg(5, lbpc_pkg::PAT_BLINK, lbpc_pkg::CNT_TOP, lbpc_pkg::CNT_TOP, 0);
        add_cfg(6, lbpc_pkg::PAT_OFF, 2, 2, 2);
        repeat (12) add_tick();
        add_cfg(5, PAT_RSVD_FIRST, 1, 1, 1);                           // reserved code goes dark
        add_cfg(1, lbpc_pkg::PAT_FLICKER, 0, 0, 0);
        add_tick();
        add_tick();

        // random: mostly configure bursts followed by runs of ticks, the rest loose items
        while (total_items < ITEM_TARGET)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                n_cfg  = $urandom_range(1, 3);
                n_tick = $urandom_range(2, 30);
                repeat (n_cfg)
                    add_cfg(lbpc_pkg::INDEX_W'($urandom), pick_pattern(),
                            pick_limit(), pick_limit(), pick_limit());
                repeat (n_tick) add_tick();
            end
            else if ($urandom_range(0, 1))
            begin
                add_cfg(lbpc_pkg::INDEX_W'($urandom), lbpc_pkg::PAT_W'($urandom),
                        lbpc_pkg::CNT_W'($urandom), lbpc_pkg::CNT_W'($urandom),
                        lbpc_pkg::CNT_W'($urandom));
            end
            else
            begin
                add_tick();
            end
        end

        // drain: everything offered, accepted and answered
        @(posedge rst_n);
        while (pend_q.size() > 0 || req_if.valid || levels_q.size() > 0)
            @(negedge clk);
        // a tick sweeps every led before its result; give stray results time to show up
        repeat (4 * lbpc_pkg::NUM_LEDS) @(negedge clk);

        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
